// ===== sv/wrsp_pkg.sv =====
// Package with the chunk identifiers, parse phases and result kinds of the WAV stream parser.
package wrsp_pkg;

	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;
	localparam logic [31:0] ID_LIST = 32'h5453_494c;
	localparam logic [31:0] ID_FACT = 32'h7463_6166;

	localparam logic [31:0] FMT_MAX_BYTES = 32'd1024;
	localparam logic [1:0]  KEPT_CHANNELS = 2'd2;

	typedef enum logic [2:0] {
		PH_RIFF = 3'd0,
		PH_HDR  = 3'd1,
		PH_FMT  = 3'd2,
		PH_DATA = 3'd3,
		PH_SKIP = 3'd4,
		PH_PAD  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_SAMPLE  = 3'd0,
		EV_HDR_ERR = 3'd1,
		EV_SKIPPED = 3'd2,
		EV_FORMAT  = 3'd3,
		EV_NO_FMT  = 3'd4
	} event_t;

	// One result item as it leaves the parser core.
	typedef struct packed {
		logic [3:0]  warn_flags;
		logic        channel;
		logic [15:0] sample_value;
		event_t      event_kind;
	} result_t;

endpackage

// ===== sv/wrsp_core.sv =====
// Parser core: takes one registered byte per cycle while in_valid is high and updates the chunk walk state.
module wrsp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 in_start,
	output logic                 res_valid,
	output wrsp_pkg::result_t    res
);

	wrsp_pkg::phase_t phase_q, phase_d;
	logic [31:0] offset_q, offset_d;
	logic [31:0] ident_q, ident_d;
	logic [31:0] length_q, length_d;
	logic [15:0] tag_q, tag_d, chans_q, chans_d, align_q, align_d, bits_q, bits_d;
	logic [2:0]  sbytes_q, sbytes_d;
	logic [15:0] fpos_q, fpos_d;
	logic [7:0]  hold_q, hold_d;
	logic        seen_q, seen_d, stop_q, stop_d;
	// Per-channel byte offsets within the frame are tracked incrementally.
	logic [15:0] within_q, within_d;
	logic [15:0] ch_q, ch_d;

	// Working copies after an optional file restart.
	wrsp_pkg::phase_t ph;
	logic [31:0] off, idt, len;
	logic [15:0] tg, cc, ba, bp, fp, wi, cn;
	logic [2:0]  sb;
	logic        sn, st;
	logic [31:0] off_inc, idt_sh, len_sh;
	logic [2:0]  fsb;
	logic [3:0]  fwarn;
	logic [32:0] fstart;
	logic [1:0]  kept;

	// Format check on the current format registers, used at the end of fmt.
	function automatic logic [6:0] fmt_check(input logic [15:0] t, input logic [15:0] c,
			input logic [15:0] a, input logic [15:0] b);
		logic [2:0]  s;
		logic [3:0]  w;
		logic [18:0] p;
		begin
			w = 4'd0;
			if (b >= 16'd1 && b <= 16'd8) s = 3'd1;
			else if (b >= 16'd9 && b <= 16'd16) s = 3'd2;
			else if (b >= 16'd17 && b <= 16'd24) s = 3'd3;
			else if (b >= 16'd25 && b <= 16'd32) s = 3'd4;
			else begin
				s = 3'd0;
				w[3] = 1'b1;
			end
			if (t != 16'd1) w[0] = 1'b1;
			if (c < 16'd1 || c > 16'd2) w[1] = 1'b1;
			p = {16'd0, s} * {3'd0, c};
			if ({3'd0, a} != p) w[2] = 1'b1;
			fmt_check = {s, w};
		end
	endfunction

	// Next state and the result of this byte.
	always_comb begin
		ph = phase_q; off = offset_q; idt = ident_q; len = length_q;
		tg = tag_q; cc = chans_q; ba = align_q; bp = bits_q; sb = sbytes_q;
		fp = fpos_q; wi = within_q; cn = ch_q; sn = seen_q; st = stop_q;
		hold_d = hold_q;
		res_valid = 1'b0;
		res = '{warn_flags: 4'd0, channel: 1'b0, sample_value: 16'd0,
			event_kind: wrsp_pkg::EV_SAMPLE};
		fsb = 3'd0; fwarn = 4'd0; fstart = 33'd0; kept = 2'd0;
		if (in_start) begin
			ph = wrsp_pkg::PH_RIFF; off = '0; idt = '0; len = '0;
			tg = '0; cc = '0; ba = '0; bp = '0; sb = '0; fp = '0; wi = '0; cn = '0;
			sn = 1'b0; st = 1'b0; hold_d = 8'd0;
		end
		off_inc = off + 32'd1;
		idt_sh = {in_byte, idt[31:8]};
		len_sh = {in_byte, len[31:8]};
		if (in_valid && !st) begin
			case (ph)
				wrsp_pkg::PH_RIFF: begin
					if (off < 32'd4) idt = idt_sh;
					else if (off >= 32'd8) len = len_sh;
					off = off_inc;
					if (off_inc == 32'd12) begin
						off = '0;
						if (idt != wrsp_pkg::ID_RIFF || len != wrsp_pkg::ID_WAVE) begin
							st = 1'b1;
							res_valid = 1'b1;
							res.event_kind = wrsp_pkg::EV_HDR_ERR;
						end else begin
							ph = wrsp_pkg::PH_HDR;
						end
					end
				end
				wrsp_pkg::PH_HDR: begin
					if (off < 32'd4) idt = idt_sh;
					else len = len_sh;
					off = off_inc;
					if (off_inc == 32'd8) begin
						off = '0;
						ph = wrsp_pkg::PH_SKIP;
						if (idt == wrsp_pkg::ID_FMT) begin
							if (len > wrsp_pkg::FMT_MAX_BYTES) begin
								res_valid = 1'b1;
								res.event_kind = wrsp_pkg::EV_SKIPPED;
							end else begin
								tg = '0; cc = '0; ba = '0; bp = '0;
								ph = wrsp_pkg::PH_FMT;
								if (len == 32'd0) begin
									{fsb, fwarn} = fmt_check(16'd0, 16'd0, 16'd0, 16'd0);
									sb = fsb;
									res_valid = 1'b1;
									res.event_kind = wrsp_pkg::EV_FORMAT;
									res.warn_flags = fwarn;
								end
							end
						end else if (idt == wrsp_pkg::ID_DATA) begin
							res_valid = 1'b1;
							if (sb == 3'd0) begin
								res.event_kind = wrsp_pkg::EV_NO_FMT;
							end else if (sn) begin
								res.event_kind = wrsp_pkg::EV_SKIPPED;
							end else begin
								res_valid = 1'b0;
								sn = 1'b1;
								fp = '0; wi = '0; cn = '0;
								ph = wrsp_pkg::PH_DATA;
							end
						end else if (idt != wrsp_pkg::ID_LIST && idt != wrsp_pkg::ID_FACT) begin
							res_valid = 1'b1;
							res.event_kind = wrsp_pkg::EV_SKIPPED;
						end
						if (len == 32'd0) ph = wrsp_pkg::PH_HDR;
					end
				end
				wrsp_pkg::PH_FMT: begin
					case (off[3:0])
						4'd0:  if (off[31:4] == '0) tg[7:0]  = in_byte;
						4'd1:  if (off[31:4] == '0) tg[15:8] = in_byte;
						4'd2:  if (off[31:4] == '0) cc[7:0]  = in_byte;
						4'd3:  if (off[31:4] == '0) cc[15:8] = in_byte;
						4'd12: if (off[31:4] == '0) ba[7:0]  = in_byte;
						4'd13: if (off[31:4] == '0) ba[15:8] = in_byte;
						4'd14: if (off[31:4] == '0) bp[7:0]  = in_byte;
						4'd15: if (off[31:4] == '0) bp[15:8] = in_byte;
						default: ;
					endcase
					off = off_inc;
					if (off_inc == len) begin
						{fsb, fwarn} = fmt_check(tg, cc, ba, bp);
						sb = fsb;
						res_valid = 1'b1;
						res.event_kind = wrsp_pkg::EV_FORMAT;
						res.warn_flags = fwarn;
						off = '0;
						ph = len[0] ? wrsp_pkg::PH_PAD : wrsp_pkg::PH_HDR;
					end
				end
				wrsp_pkg::PH_DATA: begin
					if (ba != 16'd0 && sb != 3'd0) begin
						fstart = {1'b0, off} - {17'd0, fp} + {17'd0, ba};
						kept = (cc < {14'd0, wrsp_pkg::KEPT_CHANNELS}) ? cc[1:0] :
							wrsp_pkg::KEPT_CHANNELS;
						if (fstart <= {1'b0, len} && cn < {14'd0, kept}) begin
							if (sb == 3'd1) begin
								res_valid = 1'b1;
								res.sample_value = {in_byte ^ 8'h80, 8'd0};
								res.channel = cn[0];
							end else if (wi == {13'd0, sb} - 16'd2) begin
								hold_d = in_byte;
							end else if (wi == {13'd0, sb} - 16'd1) begin
								res_valid = 1'b1;
								res.sample_value = {in_byte, hold_q};
								res.channel = cn[0];
							end
						end
						if (fp + 16'd1 >= ba || fp == 16'hffff) begin
							fp = '0; wi = '0; cn = '0;
						end else begin
							fp = fp + 16'd1;
							if (wi + 16'd1 == {13'd0, sb}) begin
								wi = '0;
								cn = cn + 16'd1;
							end else begin
								wi = wi + 16'd1;
							end
						end
					end
					off = off_inc;
					if (off_inc == len) begin
						off = '0;
						ph = len[0] ? wrsp_pkg::PH_PAD : wrsp_pkg::PH_HDR;
					end
				end
				wrsp_pkg::PH_SKIP: begin
					off = off_inc;
					if (off_inc == len) begin
						off = '0;
						ph = len[0] ? wrsp_pkg::PH_PAD : wrsp_pkg::PH_HDR;
					end
				end
				wrsp_pkg::PH_PAD: begin
					off = '0;
					ph = wrsp_pkg::PH_HDR;
				end
				default: ;
			endcase
		end
		phase_d = ph; offset_d = off; ident_d = idt; length_d = len;
		tag_d = tg; chans_d = cc; align_d = ba; bits_d = bp; sbytes_d = sb;
		fpos_d = fp; within_d = wi; ch_d = cn; seen_d = sn; stop_d = st;
	end

	// State registers, loaded only when a byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wrsp_pkg::PH_RIFF;
			offset_q <= '0; ident_q <= '0; length_q <= '0;
			tag_q <= '0; chans_q <= '0; align_q <= '0; bits_q <= '0;
			sbytes_q <= '0; fpos_q <= '0; within_q <= '0; ch_q <= '0;
			hold_q <= '0; seen_q <= 1'b0; stop_q <= 1'b0;
		end else if (in_valid) begin
			phase_q <= phase_d;
			offset_q <= offset_d; ident_q <= ident_d; length_q <= length_d;
			tag_q <= tag_d; chans_q <= chans_d; align_q <= align_d; bits_q <= bits_d;
			sbytes_q <= sbytes_d; fpos_q <= fpos_d; within_q <= within_d; ch_q <= ch_d;
			hold_q <= hold_d; seen_q <= seen_d; stop_q <= stop_d;
		end
	end

	// A stopped parse never resumes without a new file.
	assert property (@(posedge clk) disable iff (!arst_n)
		stop_q && !(in_valid && in_start) |=> stop_q)
		else $error("parse resumed without a file start");
	// The frame position stays inside the frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wrsp_pkg::PH_DATA && align_q != 16'd0 |-> fpos_q < align_q)
		else $error("frame position beyond block align");
	// Data is entered only with a sample size known.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wrsp_pkg::PH_DATA |-> sbytes_q != 3'd0 && seen_q)
		else $error("data phase without format");

endmodule

// ===== sv/wav_riff_stream_parser.sv =====
// Top level of the WAV stream parser: input register, parser core and output skid stage.
//
//  channel | tdata fields (low bit up)           | tuser
//  s_axis  | byte_in[7:0]                         | file_start
//  m_axis  | sample_value[15:0], channel, warn[3:0] pad to 24 bits | event_kind[2:0]
//
// One byte is taken every cycle while s_axis_tready is high; the byte passes through the input
// register, and its result is loaded into the output register, or into the skid slot when stalled.
// Throughput is set by the parser core, whose state update for each byte is combinational.
// arst_n clears the walk to the RIFF header phase with no format held.
// A stalled output holds one result in the output register and one in the skid slot;
// s_axis_tready falls whenever the skid slot will still be full after the coming edge.
module wav_riff_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // byte_in[7:0]
	input  logic        s_axis_tuser,  // file_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // sample_value[15:0], channel[16], warn_flags[20:17]
	output logic [2:0]  m_axis_tuser   // event_kind[2:0]
);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        res_valid;
	wrsp_pkg::result_t res;
	logic        out_v_q, skid_v_q;
	logic        skid_next;
	wrsp_pkg::result_t out_q, skid_q;

	// Occupancy of the skid slot after the coming edge.
	always_comb begin
		if (!out_v_q || m_axis_tready) begin
			skid_next = skid_v_q && res_valid;
		end else begin
			skid_next = skid_v_q || res_valid;
		end
	end

	// Ready while the skid slot will be free for the result of the item taken now.
	assign s_axis_tready = !skid_next;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		byte_s1 <= s_axis_tdata;
		start_s1 <= s_axis_tuser;
	end

	wrsp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_byte  (byte_s1),
		.in_start (start_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// Output register with a skid slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_axis_tready) begin
				if (skid_v_q) begin
					out_v_q <= 1'b1;
					skid_v_q <= res_valid;
				end else begin
					out_v_q <= res_valid;
				end
			end else if (res_valid) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {3'd0, out_q.warn_flags, out_q.channel, out_q.sample_value};
	assign m_axis_tuser = out_q.event_kind;

	// The skid slot only fills behind a full output register.
	assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> out_v_q)
		else $error("skid slot full with empty output register");
	// No result arrives when both slots are full and the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !m_axis_tready |-> !res_valid)
		else $error("result lost on stalled output");
	// A stalled output keeps its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item changed while stalled");

endmodule
